// ===== src/ordered_list_engine_macros.svh =====
// Assertion macros shared by the ordered list engine RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define OLE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define OLE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ole_pkg.sv =====
// Types and constants of the ordered list engine.
// Depends on nothing; used by the top level and the testbench.
package ole_pkg;

   localparam int unsigned CAPACITY_DEF = 256;

   localparam int unsigned OP_W = 3;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned POS_W = 8;
   localparam int unsigned LEN_W = 9;

   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_DEL_VALUE = 3'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
   localparam logic [OP_W-1:0] OP_INS_BACK = 3'd3;
   localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_AFTER = 3'd5;
   localparam logic [OP_W-1:0] OP_DEL_LAST = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic signed [VALUE_W-1:0] value;
      logic signed [VALUE_W-1:0] anchor;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0] position;
      logic [LEN_W-1:0] length;
   } rsp_type;

endpackage

// ===== src/ordered_list_engine.sv =====
// Top level of the ordered list engine: sequencer around a value RAM and a link RAM.
// Depends on ole_pkg, ole_ram and ordered_list_engine_macros.svh.
//
// Usage. A request beat is taken at a rising edge where start is high and busy
// is low; req_data carries op, value and anchor. Exactly one response beat
// follows: rsp_valid is high for one cycle with status, position and length
// on rsp_data, and the receiver takes it at the end of that cycle.
// Sequence. Each visited node takes a link RAM read state, then a compare state.
// A request keeps busy high while it runs, and its response strobe comes in
// the first cycle with busy low again; a front insert allocates with no walk.
// A refused insert on a full store, an unused code and a delete-last on an empty
// list answer in the cycle after acceptance without raising busy. The walk goes
// through the link RAM's single read port. One request is in flight at a time.
// Reset. After reset the block runs a clearing pass that threads the free chain
// through the link RAM; busy is high during it.
// The receiver cannot stall, so responses are never held back.
`include "ordered_list_engine_macros.svh"

module ordered_list_engine
   import ole_pkg::*;
#(
   parameter int unsigned CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int unsigned IW = $clog2(CAPACITY + 1);
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [IW-1:0] NIL = IW'(CAPACITY);
   localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE = 9'b000000010,
      S_RD = 9'b000000100,
      S_CHK = 9'b000001000,
      S_ALLOC_RD = 9'b000010000,
      S_ALLOC = 9'b000100000,
      S_NEXT_RD = 9'b001000000,
      S_NEXT = 9'b010000000,
      S_WR2 = 9'b100000000
   } state_type;

   typedef enum logic [2:0] {
      A_FRONT = 3'b001,
      A_BACK = 3'b010,
      A_BEFORE = 3'b100
   } amode_type;

   state_type state_ff, state_in;
   amode_type amode_ff, amode_in;
   logic [IW-1:0] head_ff, head_in, free_ff, free_in, len_ff, len_in;
   logic [IW-1:0] cur_ff, cur_in, prev_ff, prev_in, nxt_ff, nxt_in, k_ff, k_in;
   logic [IW-1:0] w2a_ff, w2a_in, w2d_ff, w2d_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic [VALUE_W-1:0] val_ff, val_in, key_ff, key_in;
   logic [STATUS_W-1:0] stat_ff, stat_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic link_we, val_we;
   logic [IW-1:0] link_wa, link_wd, rd_a;
   logic [IW-1:0] link_rd;
   logic [VALUE_W-1:0] val_rd;
   logic [IW+POS_W-1:0] pos_wide;
   logic [IW+LEN_W-1:0] len_wide;
   logic tail_mode;

   assign tail_mode = (op_ff == OP_INS_BACK) || (op_ff == OP_DEL_LAST);
   assign pos_wide = {{POS_W{1'b0}}, k_ff};
   assign len_wide = {{LEN_W{1'b0}}, len_ff};

   always_comb begin
      state_in = state_ff;
      amode_in = amode_ff;
      head_in = head_ff;
      free_in = free_ff;
      len_in = len_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      nxt_in = nxt_ff;
      k_in = k_ff;
      w2a_in = w2a_ff;
      w2d_in = w2d_ff;
      op_in = op_ff;
      val_in = val_ff;
      key_in = key_ff;
      stat_in = stat_ff;
      pos_in = pos_ff;
      rsp_valid_in = 1'b0;
      link_we = 1'b0;
      link_wa = cur_ff;
      link_wd = NIL;
      val_we = 1'b0;
      rd_a = cur_ff;
      case (state_ff)
         S_CLEAR: begin
            link_we = 1'b1;
            link_wa = cur_ff;
            link_wd = cur_ff + 1'b1;
            cur_in = cur_ff + 1'b1;
            if (cur_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in = req_data.op;
               val_in = req_data.value;
               key_in = (req_data.op == OP_INS_BEFORE) ? req_data.anchor : req_data.value;
               cur_in = head_ff;
               prev_in = NIL;
               k_in = '0;
               pos_in = '0;
               stat_in = ST_OK;
               amode_in = A_FRONT;
               state_in = S_RD;
               case (req_data.op)
                  OP_INS_FRONT: begin
                     state_in = S_ALLOC_RD;
                  end
                  OP_INS_BACK: begin
                     if (head_ff == NIL) begin
                        state_in = S_ALLOC_RD;
                     end
                  end
                  OP_DEL_LAST: begin
                     if (head_ff == NIL) begin
                        stat_in = ST_MISS;
                        rsp_valid_in = 1'b1;
                        state_in = S_IDLE;
                     end
                  end
                  OP_DEL_VALUE, OP_SEARCH, OP_INS_BEFORE, OP_DEL_AFTER: begin
                  end
                  default: begin
                     stat_in = ST_MISS;
                     rsp_valid_in = 1'b1;
                     state_in = S_IDLE;
                  end
               endcase
               if ((free_ff == NIL) && ((req_data.op == OP_INS_FRONT) ||
                   (req_data.op == OP_INS_BACK) || (req_data.op == OP_INS_BEFORE))) begin
                  stat_in = ST_FULL;
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_RD: begin
            rd_a = cur_ff;
            if (cur_ff == NIL) begin
               if (op_ff == OP_INS_BEFORE) begin
                  amode_in = A_FRONT;
                  state_in = S_ALLOC_RD;
               end else begin
                  stat_in = ST_MISS;
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (tail_mode) begin
               if (link_rd == NIL) begin
                  if (op_ff == OP_INS_BACK) begin
                     amode_in = A_BACK;
                     state_in = S_ALLOC_RD;
                  end else begin
                     if (prev_ff == NIL) begin
                        head_in = NIL;
                     end else begin
                        link_we = 1'b1;
                        link_wa = prev_ff;
                        link_wd = NIL;
                     end
                     w2a_in = cur_ff;
                     w2d_in = free_ff;
                     free_in = cur_ff;
                     len_in = len_ff - 1'b1;
                     state_in = S_WR2;
                  end
               end else begin
                  prev_in = cur_ff;
                  cur_in = link_rd;
                  state_in = S_RD;
               end
            end else if (val_rd == key_ff) begin
               case (op_ff)
                  OP_SEARCH: begin
                     pos_in = pos_wide[POS_W-1:0];
                     rsp_valid_in = 1'b1;
                     state_in = S_IDLE;
                  end
                  OP_DEL_VALUE: begin
                     if (prev_ff == NIL) begin
                        head_in = link_rd;
                     end else begin
                        link_we = 1'b1;
                        link_wa = prev_ff;
                        link_wd = link_rd;
                     end
                     w2a_in = cur_ff;
                     w2d_in = free_ff;
                     free_in = cur_ff;
                     len_in = len_ff - 1'b1;
                     state_in = S_WR2;
                  end
                  OP_INS_BEFORE: begin
                     amode_in = (prev_ff == NIL) ? A_FRONT : A_BEFORE;
                     state_in = S_ALLOC_RD;
                  end
                  default: begin
                     if (link_rd == NIL) begin
                        stat_in = ST_MISS;
                        rsp_valid_in = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        nxt_in = link_rd;
                        state_in = S_NEXT_RD;
                     end
                  end
               endcase
            end else begin
               prev_in = cur_ff;
               cur_in = link_rd;
               k_in = k_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_ALLOC_RD: begin
            rd_a = free_ff;
            state_in = S_ALLOC;
         end
         S_ALLOC: begin
            val_we = 1'b1;
            link_we = 1'b1;
            link_wa = free_ff;
            free_in = link_rd;
            len_in = len_ff + 1'b1;
            w2d_in = free_ff;
            case (amode_ff)
               A_BACK: begin
                  link_wd = NIL;
                  w2a_in = cur_ff;
                  state_in = S_WR2;
               end
               A_BEFORE: begin
                  link_wd = cur_ff;
                  w2a_in = prev_ff;
                  state_in = S_WR2;
               end
               default: begin
                  link_wd = head_ff;
                  head_in = free_ff;
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_NEXT_RD: begin
            rd_a = nxt_ff;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            link_we = 1'b1;
            link_wa = cur_ff;
            link_wd = link_rd;
            w2a_in = nxt_ff;
            w2d_in = free_ff;
            free_in = nxt_ff;
            len_in = len_ff - 1'b1;
            state_in = S_WR2;
         end
         S_WR2: begin
            link_we = 1'b1;
            link_wa = w2a_ff;
            link_wd = w2d_ff;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         head_ff <= NIL;
         free_ff <= '0;
         len_ff <= '0;
         cur_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         free_ff <= free_in;
         len_ff <= len_in;
         cur_ff <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      amode_ff <= amode_in;
      prev_ff <= prev_in;
      nxt_ff <= nxt_in;
      k_ff <= k_in;
      w2a_ff <= w2a_in;
      w2d_ff <= w2d_in;
      op_ff <= op_in;
      val_ff <= val_in;
      key_ff <= key_in;
      stat_ff <= stat_in;
      pos_ff <= pos_in;
   end

   ole_ram #(
      .WIDTH(IW),
      .DEPTH(CAPACITY)
   ) u_link_ram (
      .clock(clock),
      .we(link_we),
      .waddr(link_wa[AW-1:0]),
      .wdata(link_wd),
      .raddr(rd_a[AW-1:0]),
      .rdata(link_rd)
   );

   ole_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(CAPACITY)
   ) u_value_ram (
      .clock(clock),
      .we(val_we),
      .waddr(free_ff[AW-1:0]),
      .wdata(val_ff),
      .raddr(rd_a[AW-1:0]),
      .rdata(val_rd)
   );

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.status = stat_ff;
   assign rsp_data.position = pos_ff;
   assign rsp_data.length = len_wide[LEN_W-1:0];

   `OLE_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy || rsp_valid, "accepted beat lost")
   `OLE_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy, "response strobe while busy")
   `OLE_ASSERT_IMP(a_full_len, clock, reset, free_ff == NIL, len_ff == NIL, "free chain empty early")
   `OLE_ASSERT_IMP(a_empty_len, clock, reset, state_ff != S_CLEAR, (head_ff == NIL) == (len_ff == '0), "head and length disagree")

endmodule

// ===== src/ole_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ole_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the ordered list engine: directed and random request beats,
// predicted by a behavioral linked list and compared field by field with each response.
// Depends on ole_pkg and the ordered_list_engine RTL.
module testbench;
   import ole_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CAP = CAPACITY_DEF;
   localparam int unsigned NIL = CAP;
   localparam logic [OP_W-1:0] OP_NONE = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;

   ordered_list_engine dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [31:0] list_vals [CAP];
   int unsigned list_links [CAP];
   int unsigned list_head;
   int unsigned free_top;
   int unsigned list_len;

   rsp_type pending_rsp [$];
   int errors = 0;
   int beats_sent = 0;
   int rsp_seen = 0;
   int send_gap_pct = 0;

   function automatic int unsigned find_value(input logic [31:0] v, output int unsigned prv,
                                              output int unsigned pos);
      int unsigned cur;
      int unsigned k;
      cur = list_head;
      prv = NIL;
      k = 0;
      while (cur < NIL && k < CAP) begin
         if (list_vals[cur] == v) break;
         prv = cur;
         cur = list_links[cur];
         k++;
      end
      if (k >= CAP) cur = NIL;
      pos = k;
      return cur;
   endfunction

   function automatic int unsigned grab_node(input logic [31:0] v);
      int unsigned n;
      n = free_top;
      if (n >= NIL) return NIL;
      free_top = list_links[n];
      list_vals[n] = v;
      list_links[n] = NIL;
      list_len++;
      return n;
   endfunction

   function automatic void drop_node(input int unsigned n);
      if (n >= NIL) return;
      list_links[n] = free_top;
      free_top = n;
      if (list_len > 0) list_len--;
   endfunction

   function automatic logic [STATUS_W-1:0] link_front(input logic [31:0] v);
      int unsigned n;
      n = grab_node(v);
      if (n >= NIL) return ST_FULL;
      list_links[n] = list_head;
      list_head = n;
      return ST_OK;
   endfunction

   function automatic rsp_type predict_list_op(input req_type r);
      rsp_type o;
      int unsigned cur, prv, pos, n, k;
      o.status = ST_MISS;
      o.position = '0;
      case (r.op)
         OP_INS_FRONT: o.status = link_front(r.value);
         OP_DEL_VALUE: begin
            cur = find_value(r.value, prv, pos);
            if (cur < NIL) begin
               if (prv >= NIL) list_head = list_links[cur];
               else list_links[prv] = list_links[cur];
               drop_node(cur);
               o.status = ST_OK;
            end
         end
         OP_SEARCH: begin
            cur = find_value(r.value, prv, pos);
            if (cur < NIL) begin
               o.status = ST_OK;
               o.position = pos[POS_W-1:0];
            end
         end
         OP_INS_BACK: begin
            if (free_top >= NIL) o.status = ST_FULL;
            else if (list_head >= NIL) o.status = link_front(r.value);
            else begin
               cur = list_head;
               k = 0;
               while (list_links[cur] < NIL && k < CAP) begin
                  cur = list_links[cur];
                  k++;
               end
               n = grab_node(r.value);
               list_links[cur] = n;
               o.status = ST_OK;
            end
         end
         OP_INS_BEFORE: begin
            if (free_top >= NIL) o.status = ST_FULL;
            else begin
               cur = find_value(r.anchor, prv, pos);
               if (cur >= NIL || prv >= NIL) o.status = link_front(r.value);
               else begin
                  n = grab_node(r.value);
                  list_links[n] = cur;
                  list_links[prv] = n;
                  o.status = ST_OK;
               end
            end
         end
         OP_DEL_AFTER: begin
            cur = find_value(r.value, prv, pos);
            if (cur < NIL) begin
               n = list_links[cur];
               if (n < NIL) begin
                  list_links[cur] = list_links[n];
                  drop_node(n);
                  o.status = ST_OK;
               end
            end
         end
         OP_DEL_LAST: begin
            if (list_head < NIL) begin
               prv = NIL;
               cur = list_head;
               k = 0;
               while (list_links[cur] < NIL && k < CAP) begin
                  prv = cur;
                  cur = list_links[cur];
                  k++;
               end
               if (prv >= NIL) list_head = NIL;
               else list_links[prv] = NIL;
               drop_node(cur);
               o.status = ST_OK;
            end
         end
         default: ;
      endcase
      o.length = list_len[LEN_W-1:0];
      return o;
   endfunction

   task automatic send_beat(input logic [OP_W-1:0] op, input logic [31:0] v,
                            input logic [31:0] a);
      req_type r;
      r.op = op;
      r.value = v;
      r.anchor = a;
      while ($urandom_range(99, 0) < send_gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(predict_list_op(r));
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (2 * CAP + 10) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         rsp_type e;
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with nothing expected, actual %p", $time, rsp_data);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.status !== e.status || rsp_data.position !== e.position ||
                rsp_data.length !== e.length) begin
               $display("%0t: expected %p actual %p", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9, 0))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom();
         default: return $urandom_range(15, 0);
      endcase
   endfunction

   task automatic test_directed();
      send_beat(OP_DEL_LAST, 0, 0);
      send_beat(OP_DEL_VALUE, 5, 0);
      send_beat(OP_DEL_AFTER, 5, 0);
      send_beat(OP_SEARCH, 5, 0);
      send_beat(OP_INS_BACK, 32'h8000_0000, 0);
      send_beat(OP_INS_FRONT, 32'h7fff_ffff, 0);
      send_beat(OP_INS_BEFORE, 32'hffff_ffff, 32'h8000_0000);
      send_beat(OP_INS_BEFORE, 1, 32'h7fff_ffff);
      send_beat(OP_INS_BEFORE, 2, 32'h1234_5678);
      send_beat(OP_SEARCH, 32'h8000_0000, 0);
      send_beat(OP_DEL_AFTER, 32'h8000_0000, 0);
      send_beat(OP_DEL_AFTER, 2, 0);
      send_beat(OP_NONE, 32'h5555_aaaa, 32'haaaa_5555);
      send_beat(OP_DEL_VALUE, 2, 0);
      send_beat(OP_DEL_LAST, 0, 0);
      send_beat(OP_DEL_LAST, 0, 0);
      send_beat(OP_DEL_LAST, 0, 0);
      drain_responses();
   endtask

   task automatic test_full_store();
      for (int i = 0; i < CAP; i++) send_beat(OP_INS_FRONT, i, 0);
      send_beat(OP_INS_FRONT, 1, 0);
      send_beat(OP_INS_BACK, 1, 0);
      send_beat(OP_INS_BEFORE, 1, 3);
      send_beat(OP_SEARCH, 0, 0);
      send_beat(OP_DEL_AFTER, 1, 0);
      for (int i = 0; i < CAP; i++) send_beat(OP_DEL_LAST, 0, 0);
      drain_responses();
   endtask

   task automatic test_random(input int count);
      logic [OP_W-1:0] op;
      for (int i = 0; i < count; i++) begin
         op = $urandom_range(99, 0) < 2 ? OP_NONE : OP_W'($urandom_range(6, 0));
         if (list_len < 6 && $urandom_range(1, 0)) op = OP_INS_BACK;
         send_beat(op, pick_value(), pick_value());
      end
      drain_responses();
   endtask

   initial begin
      list_head = NIL;
      free_top = 0;
      list_len = 0;
      for (int i = 0; i < CAP; i++) list_links[i] = i + 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_gap_pct = 10;
      test_directed();
      test_full_store();
      test_random(150);
      send_gap_pct = 73;
      test_random(130);
      send_gap_pct = 0;
      test_random(130);
      $display("Covered %0d request beats and %0d response beats,", beats_sent, rsp_seen);
      $display("including all seven operations, an unused code and a full store.");
      if (errors == 0) begin
         $display("ordered_list_engine: match");
      end else begin
         $display("ordered_list_engine: mismatch");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("ordered_list_engine: mismatch");
      $finish;
   end
endmodule
